// File: src/lalm_pkg.sv
// Shared types and codes for the array-backed linked list manager.
// No dependencies; every other file imports this package.
package lalm_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 9;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 9;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_WSTART,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_UNLINK1,
    S_UNLINK2,
    S_RESP
  } state_t;

endpackage

// File: src/lalm_req_if.sv
// Request channel: valid/ready handshake carrying one list command.
// Depends on lalm_pkg for field widths.
interface lalm_req_if import lalm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

// File: src/lalm_rsp_if.sv
// Response channel: valid/ready handshake carrying one command result.
// Depends on lalm_pkg for field widths.
interface lalm_rsp_if import lalm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   data_out;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output data_out, output slot, output count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input slot, input count,
                  output ready);
endinterface

// File: src/array_linked_list_manager_top.sv
// Linked list manager over a fixed slot store, with free-slot recycling.
// Channels: req (sink) takes one command (opcode, position, value); rsp
// (source) returns status, data_out, slot and count for every command.
// Flow: clear, unused opcodes and failed commands go from idle straight to
// the response state, which registers rsp.valid. A push or insert may first
// read the recycle chain (alloc); a push then writes link1 and, with a
// predecessor, link2. A positional command walks next links from the head
// one memory read per cycle; then a read responds, an insert links in and a
// remove unlinks (unlink1, unlink2). The next-link walk sets the rate. One
// command is in flight at a time; req.ready is high only while idle.
// Never-used slots are handed out in order from a counter; removed slots
// join a FIFO chain in the link memory and are reused after the fresh ones.
// Reset (synchronous, rst high) empties the list; no memory
// sweep is needed. Clear does the same as a command and answers ok.
// When rsp stalls, the finished result holds in the output register and
// the block accepts and works the next command, then waits to hand it over.
module array_linked_list_manager_top import lalm_pkg::*; #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  lalm_req_if.sink  req,
  lalm_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int PW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  state_t state, state_next;

  logic [LW-1:0] head, tail, rec_head, rec_tail, fresh, elem_count;
  logic          rec_valid;
  logic [LW-1:0] cur, prev, k, target, s_slot, lp, ln;
  logic          mid;
  logic [OPCODE_W-1:0]    cmd;
  logic [VALUE_WIDTH-1:0] val;
  logic [STATUS_W-1:0]    res_status;
  logic [VALUE_WIDTH-1:0] res_data;
  logic [LW-1:0]          res_slot;

  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [WORD_W-1:0]      out_data;
  logic [SLOT_W-1:0]      out_slot;
  logic [COUNT_W-1:0]     out_count;

  logic [AW-1:0]          rd_addr;
  logic [LW-1:0]          link_rdata;
  logic [VALUE_WIDTH-1:0] pay_rdata;
  logic                   link_we, pay_we;
  logic [AW-1:0]          link_waddr;
  logic [LW-1:0]          link_wdata;

  // request decode
  logic          acc, is_ins, is_walk, range_bad, full_bad, use_fresh, need_rd;
  logic          ins_mid, at_front;
  logic [PW-1:0] pos_w, cnt_w;
  logic          resp_go;

  assign acc     = req.valid & req.ready;
  assign resp_go = (state == S_RESP) && (!out_valid || rsp.ready);

  always_comb begin
    pos_w     = PW'(req.position);
    cnt_w     = PW'(elem_count);
    is_ins    = (req.opcode == OP_PUSH_FRONT) || (req.opcode == OP_PUSH_BACK) ||
                (req.opcode == OP_INSERT);
    is_walk   = (req.opcode == OP_REMOVE) || (req.opcode == OP_READ);
    range_bad = ((req.opcode == OP_INSERT) && (pos_w > cnt_w)) ||
                (is_walk && (pos_w >= cnt_w));
    full_bad  = is_ins && !range_bad && (elem_count == NIL);
    use_fresh = (fresh != NIL);
    need_rd   = is_ins && !range_bad && !full_bad && !use_fresh && (rec_head != rec_tail);
    at_front  = (req.opcode == OP_PUSH_FRONT) ||
                ((req.opcode == OP_INSERT) && (pos_w == '0));
    ins_mid   = (req.opcode == OP_INSERT) && (pos_w != '0) && (pos_w != cnt_w);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (range_bad || full_bad || !(is_ins || is_walk)) begin
            state_next = S_RESP;
          end else if (is_walk) begin
            state_next = S_WSTART;
          end else if (need_rd) begin
            state_next = S_ALLOC;
          end else begin
            state_next = ins_mid ? S_WSTART : S_LINK1;
          end
        end
      end
      S_ALLOC:  state_next = mid ? S_WSTART : S_LINK1;
      S_WSTART: state_next = S_WALK;
      S_WALK: begin
        if (k == target) begin
          if (cmd == OP_INSERT) begin
            state_next = S_LINK1;
          end else if (cmd == OP_REMOVE) begin
            state_next = S_UNLINK1;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_LINK1:   state_next = (lp != NIL) ? S_LINK2 : S_RESP;
      S_LINK2:   state_next = S_RESP;
      S_UNLINK1: state_next = S_UNLINK2;
      S_UNLINK2: state_next = S_RESP;
      S_RESP:    state_next = resp_go ? S_IDLE : S_RESP;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    req.ready  = (state == S_IDLE);
    rd_addr    = '0;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    pay_we     = 1'b0;
    unique case (state)
      S_IDLE:   rd_addr = rec_head[AW-1:0];
      S_WSTART: rd_addr = head[AW-1:0];
      S_WALK:   rd_addr = link_rdata[AW-1:0];
      S_LINK1: begin
        link_we    = 1'b1;
        link_waddr = s_slot[AW-1:0];
        link_wdata = ln;
        pay_we     = 1'b1;
      end
      S_LINK2: begin
        link_we    = 1'b1;
        link_waddr = lp[AW-1:0];
        link_wdata = s_slot;
      end
      S_UNLINK1: begin
        link_we    = (lp != NIL);
        link_waddr = lp[AW-1:0];
        link_wdata = ln;
      end
      S_UNLINK2: begin
        link_we    = rec_valid;
        link_waddr = rec_tail[AW-1:0];
        link_wdata = s_slot;
      end
      default: rd_addr = '0;
    endcase
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.data_out = out_data;
  assign rsp.slot     = out_slot;
  assign rsp.count    = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= NIL;
      tail       <= NIL;
      rec_head   <= '0;
      rec_tail   <= '0;
      rec_valid  <= 1'b0;
      fresh      <= '0;
      elem_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (resp_go) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cmd        <= req.opcode;
            val        <= VALUE_WIDTH'(req.value);
            res_data   <= '0;
            res_slot   <= '0;
            mid        <= ins_mid;
            target     <= ins_mid ? LW'(req.position) - 1'b1 : LW'(req.position);
            res_status <= range_bad ? ST_RANGE : (full_bad ? ST_FULL : ST_OK);
            if (at_front) begin
              lp <= NIL;
              ln <= head;
            end else begin
              lp <= tail;
              ln <= NIL;
            end
            if (is_ins && !range_bad && !full_bad) begin
              if (use_fresh) begin
                s_slot <= fresh;
                fresh  <= fresh + 1'b1;
              end else begin
                s_slot <= rec_head;
                if (rec_head == rec_tail) begin
                  rec_valid <= 1'b0;
                end
              end
            end
            if (req.opcode == OP_CLEAR) begin
              head       <= NIL;
              tail       <= NIL;
              fresh      <= '0;
              rec_valid  <= 1'b0;
              elem_count <= '0;
            end
          end
        end
        S_ALLOC: rec_head <= link_rdata;
        S_WSTART: begin
          cur  <= head;
          prev <= NIL;
          k    <= '0;
        end
        S_WALK: begin
          if (k != target) begin
            prev <= cur;
            cur  <= link_rdata;
            k    <= k + 1'b1;
          end else begin
            ln <= link_rdata;
            if (cmd == OP_INSERT) begin
              lp <= cur;
            end else begin
              lp       <= prev;
              s_slot   <= cur;
              res_slot <= cur;
              res_data <= pay_rdata;
            end
          end
        end
        S_LINK1: begin
          if (lp == NIL) begin
            head <= s_slot;
          end
          if (ln == NIL) begin
            tail <= s_slot;
          end
          elem_count <= elem_count + 1'b1;
          res_slot   <= s_slot;
        end
        S_UNLINK1: begin
          if (lp == NIL) begin
            head <= ln;
          end
          if (ln == NIL) begin
            tail <= lp;
          end
          elem_count <= elem_count - 1'b1;
        end
        S_UNLINK2: begin
          // append the removed slot to the recycle chain
          if (!rec_valid) begin
            rec_head <= s_slot;
          end
          rec_tail  <= s_slot;
          rec_valid <= 1'b1;
        end
        S_RESP: begin
          if (resp_go) begin
            out_status <= res_status;
            out_data   <= WORD_W'(res_data);
            out_slot   <= SLOT_W'(res_slot);
            out_count  <= COUNT_W'(elem_count);
          end
        end
        default: ;
      endcase
    end
  end

  lalm_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .LW    (LW),
    .VW    (VALUE_WIDTH)
  ) u_store (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .link_rdata (link_rdata),
    .pay_rdata  (pay_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .pay_we     (pay_we),
    .pay_waddr  (s_slot[AW-1:0]),
    .pay_wdata  (val)
  );

endmodule

// File: src/lalm_store.sv
// Slot store: next-link memory and payload memory, one write and one
// registered read per cycle each. Depends on lalm_pkg only by convention.
module lalm_store import lalm_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int LW    = 9,
  parameter int VW    = 32
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [LW-1:0] link_rdata,
  output logic [VW-1:0] pay_rdata,
  input  logic          link_we,
  input  logic [AW-1:0] link_waddr,
  input  logic [LW-1:0] link_wdata,
  input  logic          pay_we,
  input  logic [AW-1:0] pay_waddr,
  input  logic [VW-1:0] pay_wdata
);

  logic [LW-1:0] link_mem [DEPTH];
  logic [VW-1:0] pay_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    pay_rdata <= pay_mem[rd_addr];
  end

endmodule

// File: src/lalm_chk.sv
// Port-level checker for the list manager, bound to the top level.
// Depends on lalm_pkg for status codes and field widths.
module lalm_chk import lalm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [WORD_W-1:0]   data_out,
  input logic [SLOT_W-1:0]   slot,
  input logic [COUNT_W-1:0]  count
);

  // failed commands report no data and no slot
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (data_out == '0) && (slot == '0))
    else $error("failed command reports data or slot");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_RANGE))
    else $error("undefined status code");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not idle after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data_out) &&
    $stable(slot) && $stable(count))
    else $error("stalled response changed");

endmodule

bind array_linked_list_manager_top lalm_chk u_lalm_chk (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .data_out  (rsp.data_out),
  .slot      (rsp.slot),
  .count     (rsp.count)
);

// File: verif/tb.sv
// Self-checking bench for array_linked_list_manager_top: drives list commands,
// predicts every response from a shadow copy of the slot store, checks in order.
// Depends on lalm_pkg, lalm_req_if, lalm_rsp_if and the top module.
`timescale 1ns / 100ps

module tb;
  import lalm_pkg::*;

  localparam int SLOTS = 256;
  localparam logic [8:0] NIL = 9'd256;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   data_out;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } answer_t;

  class list_scoreboard;
    logic [8:0]        nxt[SLOTS];
    logic [8:0]        prv[SLOTS];
    logic [WORD_W-1:0] word[SLOTS];
    logic [8:0]        head, tail, fhead, ftail, cnt;
    answer_t           pending_q[$];
    int                errors;

    function new();
      errors = 0;
      rebuild();
    endfunction

    function void rebuild();
      for (int i = 0; i < SLOTS; i++) begin
        nxt[i] = 9'(i + 1);
        prv[i] = NIL;
      end
      nxt[SLOTS-1] = NIL;
      head = NIL;
      tail = NIL;
      fhead = 9'd0;
      ftail = 9'(SLOTS - 1);
      cnt = 9'd0;
    endfunction

    function logic [8:0] walk(logic [8:0] pos);
      logic [8:0] s;
      int k;
      s = head;
      k = 0;
      while (k < pos && s < NIL) begin
        s = nxt[s];
        k++;
      end
      return s;
    endfunction

    // Take the first free slot and link it between two neighbors (either may be NIL).
    function logic [8:0] link_in(logic [8:0] bef, logic [8:0] aft, logic [WORD_W-1:0] v);
      logic [8:0] s;
      s = fhead;
      if (s >= NIL) return NIL;
      if (nxt[s] < NIL) fhead = nxt[s];
      else begin
        fhead = NIL;
        ftail = NIL;
      end
      word[s] = v;
      prv[s] = bef;
      nxt[s] = aft;
      if (bef < NIL) nxt[bef] = s;
      else head = s;
      if (aft < NIL) prv[aft] = s;
      else tail = s;
      cnt++;
      return s;
    endfunction

    function void note_request(logic [2:0] op, logic [8:0] pos, logic [WORD_W-1:0] v);
      answer_t a;
      logic [8:0] s, p, n;
      a = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
          if (op == OP_INSERT && pos > cnt) a.status = ST_RANGE;
          else if (cnt >= SLOTS || fhead >= NIL) a.status = ST_FULL;
          else begin
            if (op == OP_PUSH_FRONT || (op == OP_INSERT && pos == 0))
              s = link_in(NIL, head, v);
            else if (op == OP_PUSH_BACK || pos == cnt)
              s = link_in(tail, NIL, v);
            else begin
              p = walk(pos - 9'd1);
              n = (p < NIL) ? nxt[p] : NIL;
              s = link_in(p, n, v);
            end
            a.slot = (s < NIL) ? s[7:0] : 8'd0;
          end
        end
        OP_REMOVE: begin
          s = (pos < cnt) ? walk(pos) : NIL;
          if (s >= NIL) a.status = ST_RANGE;
          else begin
            p = prv[s];
            n = nxt[s];
            if (p < NIL) nxt[p] = n;
            else head = n;
            if (n < NIL) prv[n] = p;
            else tail = p;
            // removed slot goes to the back of the free chain
            if (ftail < NIL) nxt[ftail] = s;
            else fhead = s;
            ftail = s;
            prv[s] = NIL;
            nxt[s] = NIL;
            cnt--;
            a.data_out = word[s];
            a.slot = s[7:0];
          end
        end
        OP_CLEAR: rebuild();
        OP_READ: begin
          s = (pos < cnt) ? walk(pos) : NIL;
          if (s >= NIL) a.status = ST_RANGE;
          else begin
            a.data_out = word[s];
            a.slot = s[7:0];
          end
        end
        default: ;
      endcase
      a.count = cnt;
      pending_q.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t e;
      if (pending_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.data_out !== e.data_out) begin
        $error("data_out: expected %h, got %h", e.data_out, got.data_out);
        errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot: expected %0d, got %0d", e.slot, got.slot);
        errors++;
      end
      if (got.count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_asked = 1'b0;
  int   hold_left = 0;
  list_scoreboard sb = new();

  lalm_req_if req ();
  lalm_rsp_if rsp ();

  array_linked_list_manager_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.opcode = '0;
    req.position = '0;
    req.value = '0;
    rsp.ready = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_asked) begin
      hold_asked = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready = 1'b0;
    end else begin
      rsp.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) sb.note_request(req.opcode, req.position, req.value);
    if (!rst && rsp.valid && rsp.ready)
      sb.check_answer({rsp.status, rsp.data_out, rsp.slot, rsp.count});
  end

  task automatic send_cmd(logic [2:0] op, logic [8:0] pos, logic [WORD_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.opcode = op;
    req.position = pos;
    req.value = v;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  // Mostly in-range positions, sometimes just past the end, rarely anywhere.
  function automatic logic [8:0] pick_pos();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 9'($urandom_range(0, sb.cnt));
    if (r < 92) return sb.cnt + 9'($urandom_range(0, 2));
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic random_cmds(int n);
    int r;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 18) op = OP_PUSH_FRONT;
      else if (r < 36) op = OP_PUSH_BACK;
      else if (r < 56) op = OP_INSERT;
      else if (r < 76) op = OP_REMOVE;
      else if (r < 95) op = OP_READ;
      else if (r < 97) op = OP_CLEAR;
      else op = r[0] ? OP_SPARE_HI : OP_SPARE_LO;
      send_cmd(op, pick_pos(), $urandom());
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: empty-list errors, extreme fields, every opcode
    send_cmd(OP_READ, 9'd0, '0);
    send_cmd(OP_REMOVE, 9'd0, '0);
    send_cmd(OP_INSERT, 9'd1, 32'h1234_5678);
    send_cmd(OP_PUSH_FRONT, 9'd0, 32'h0000_0000);
    send_cmd(OP_PUSH_BACK, 9'd511, 32'hFFFF_FFFF);
    send_cmd(OP_INSERT, 9'd0, 32'hAAAA_AAAA);
    send_cmd(OP_INSERT, 9'd3, 32'h5555_5555);
    send_cmd(OP_INSERT, 9'd2, 32'h8000_0001);
    send_cmd(OP_INSERT, 9'd6, 32'hDEAD_BEEF);
    send_cmd(OP_READ, 9'd4, '0);
    send_cmd(OP_READ, 9'd5, '0);
    send_cmd(OP_READ, 9'd256, 32'hFFFF_FFFF);
    send_cmd(OP_REMOVE, 9'd2, '0);
    send_cmd(OP_REMOVE, 9'd3, '0);
    send_cmd(OP_REMOVE, 9'd0, '0);
    send_cmd(OP_REMOVE, 9'd511, '0);
    send_cmd(OP_PUSH_BACK, 9'd0, 32'h0F0F_F0F0);
    send_cmd(OP_SPARE_LO, 9'd511, 32'hFFFF_FFFF);
    send_cmd(OP_SPARE_HI, 9'd0, '0);
    send_cmd(OP_READ, 9'd2, '0);
    send_cmd(OP_CLEAR, 9'd0, '0);
    send_cmd(OP_READ, 9'd0, '0);

    send_idle_pct = 26;
    recv_idle_pct = 55;
    random_cmds(110);
    send_idle_pct = 55;
    recv_idle_pct = 26;
    random_cmds(90);

    // fill the store, poke it while full, then drain part of it
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_cmd(OP_CLEAR, 9'd0, '0);
    hold_asked = 1'b1;
    while (sb.cnt < SLOTS) send_cmd($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                                    9'd0, $urandom());
    send_cmd(OP_PUSH_FRONT, 9'd0, $urandom());
    send_cmd(OP_INSERT, 9'd256, $urandom());
    send_cmd(OP_INSERT, 9'd257, $urandom());
    send_cmd(OP_READ, 9'd255, '0);
    send_cmd(OP_REMOVE, 9'd255, '0);
    send_cmd(OP_INSERT, 9'd100, $urandom());
    send_cmd(OP_PUSH_BACK, 9'd0, $urandom());
    random_cmds(60);
    for (int i = 0; i < 40; i++) send_cmd(OP_REMOVE, 9'($urandom_range(0, sb.cnt)), '0);
    random_cmds(60);

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
src/lalm_pkg.sv
src/lalm_req_if.sv
src/lalm_rsp_if.sv
src/lalm_store.sv
src/array_linked_list_manager_top.sv
src/lalm_chk.sv
verif/tb.sv
